// ===== sv/ude_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with escape stop.
package ude_pkg;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]      ESC_BYTE  = 8'h1B;
    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

    typedef enum logic [2:0] {
        PH_ACCEPT,
        PH_NEED1,
        PH_NEED2,
        PH_NEED2_E0,
        PH_NEED2_ED,
        PH_NEED3,
        PH_NEED3_F0,
        PH_NEED3_F4
    } t_phase;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            escape_stop;
        logic            last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]      n_res;
        t_result         res0;
        t_result         res1;
        t_phase          phase;
        logic [CP_W-1:0] partial;
    } t_dec;

endpackage

// ===== sv/ude_decode.sv =====
// Per-byte decode: next decoder state and up to two result words.
module ude_decode import ude_pkg::*; (
    input  logic [7:0]      i_byte,
    input  t_phase          i_phase,
    input  logic [CP_W-1:0] i_partial,
    output t_dec            o_dec
);

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        t_phase          phase;
        logic [CP_W-1:0] partial;
    } t_fresh;

    function automatic t_fresh fresh(input logic [7:0] b);
        t_fresh f;
        f.emit    = 1'b0;
        f.cp      = '0;
        f.phase   = PH_ACCEPT;
        f.partial = '0;
        case (b) inside
            [8'h00:8'h7F]: begin
                f.emit = 1'b1;
                f.cp   = {13'd0, b};
            end
            [8'hC2:8'hDF]: begin
                f.phase   = PH_NEED1;
                f.partial = {16'd0, b[4:0]};
            end
            8'hE0: begin
                f.phase = PH_NEED2_E0;
            end
            8'hED: begin
                f.phase   = PH_NEED2_ED;
                f.partial = {17'd0, b[3:0]};
            end
            [8'hE1:8'hEF]: begin
                f.phase   = PH_NEED2;
                f.partial = {17'd0, b[3:0]};
            end
            8'hF0: begin
                f.phase = PH_NEED3_F0;
            end
            [8'hF1:8'hF3]: begin
                f.phase   = PH_NEED3;
                f.partial = {18'd0, b[2:0]};
            end
            8'hF4: begin
                f.phase   = PH_NEED3_F4;
                f.partial = {18'd0, b[2:0]};
            end
            default: begin
                f.emit = 1'b1;
                f.cp   = REPL_CHAR;
            end
        endcase
        return f;
    endfunction

    t_fresh     f;
    logic [7:0] lo;
    logic [7:0] hi;
    t_phase     adv_phase;
    logic       in_rng;

    always_comb begin
        case (i_phase)
            PH_NEED2_E0: begin
                lo = 8'hA0;
                hi = 8'hBF;
            end
            PH_NEED2_ED: begin
                lo = 8'h80;
                hi = 8'h9F;
            end
            PH_NEED3_F0: begin
                lo = 8'h90;
                hi = 8'hBF;
            end
            PH_NEED3_F4: begin
                lo = 8'h80;
                hi = 8'h8F;
            end
            default: begin
                lo = 8'h80;
                hi = 8'hBF;
            end
        endcase
        case (i_phase)
            PH_NEED2, PH_NEED2_E0, PH_NEED2_ED: adv_phase = PH_NEED1;
            PH_NEED3, PH_NEED3_F0, PH_NEED3_F4: adv_phase = PH_NEED2;
            default:                            adv_phase = PH_ACCEPT;
        endcase
    end

    assign f      = fresh(i_byte);
    assign in_rng = (i_byte >= lo) && (i_byte <= hi);

    always_comb begin
        o_dec         = '0;
        o_dec.phase   = i_phase;
        o_dec.partial = i_partial;
        if (i_byte == ESC_BYTE) begin
            o_dec.phase   = PH_ACCEPT;
            o_dec.partial = '0;
            if (i_phase != PH_ACCEPT) begin
                o_dec.n_res           = 2'd2;
                o_dec.res0.code_point = REPL_CHAR;
                o_dec.res1.escape_stop = 1'b1;
                o_dec.res1.last_of_run = 1'b1;
            end else begin
                o_dec.n_res            = 2'd1;
                o_dec.res0.escape_stop = 1'b1;
                o_dec.res0.last_of_run = 1'b1;
            end
        end else if (i_phase != PH_ACCEPT) begin
            if (in_rng) begin
                o_dec.partial = {i_partial[CP_W-7:0], i_byte[5:0]};
                o_dec.phase   = adv_phase;
                if (adv_phase == PH_ACCEPT) begin
                    o_dec.n_res            = 2'd1;
                    o_dec.res0.code_point  = {i_partial[CP_W-7:0], i_byte[5:0]};
                    o_dec.res0.last_of_run = 1'b1;
                end
            end else begin
                o_dec.res0.code_point = REPL_CHAR;
                o_dec.phase           = f.phase;
                o_dec.partial         = f.partial;
                if (f.emit) begin
                    o_dec.n_res            = 2'd2;
                    o_dec.res1.code_point  = f.cp;
                    o_dec.res1.last_of_run = 1'b1;
                end else begin
                    o_dec.n_res            = 2'd1;
                    o_dec.res0.last_of_run = 1'b1;
                end
            end
        end else begin
            o_dec.phase   = f.phase;
            o_dec.partial = f.partial;
            if (f.emit) begin
                o_dec.n_res            = 2'd1;
                o_dec.res0.code_point  = f.cp;
                o_dec.res0.last_of_run = 1'b1;
            end
        end
    end

endmodule

// ===== sv/ude_fifo.sv =====
// Result queue: takes up to two result words per cycle, hands out one.
module ude_fifo import ude_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  t_result          i_res0,
    input  t_result          i_res1,
    input  logic             i_pop,
    output t_result          o_res,
    output logic             o_valid,
    output logic             o_room,
    output logic [CNT_W-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push_n);
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_count <= r_count + CNT_W'(i_push_n) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_res1;
        end
    end

    assign o_res   = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_count = r_count;

endmodule

// ===== sv/utf8_decode_until_escape.sv =====
// Strict UTF-8 byte-stream decoder that stops a run at each escape byte.
//
// Input channel: one byte per word (i_valid / o_stall). Output channel: one
// code point word per result (o_valid / i_stall) with escape_stop and
// last_of_run flags. A byte yields zero, one or two result words.
// A taken byte is held in the input register, decoded there and written to
// the result queue when the decode stage advances; the queue head is the output.
// Throughput: one byte per cycle while each byte yields at most one word
// and the output is not stalled; bytes that yield two words limit the rate to
// the single output port, one word per cycle. A four-word result queue sits
// between the decode stage and the output, so input keeps flowing while a word waits.
// The decode stage advances only when the queue has room for two words;
// otherwise the input register holds and o_stall rises.
// Reset clears the input register, the queue and the decoder state to
// accept with nothing pending. A stalled output word stays unchanged.
module utf8_decode_until_escape import ude_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte_in,
    output logic            o_stall,
    output logic            o_valid,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_escape_stop,
    output logic            o_last_of_run,
    input  logic            i_stall
);

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    t_phase          r_phase;
    logic [CP_W-1:0] r_partial;

    t_dec             dec;
    t_result          q_res;
    logic             q_room;
    logic [CNT_W-1:0] q_count;
    logic             advance;
    logic [1:0]       push_n;

    assign advance = r_in_vld && q_room;
    assign o_stall = r_in_vld && !q_room;
    assign push_n  = advance ? dec.n_res : 2'd0;

    ude_decode u_decode (
        .i_byte    (r_in_byte),
        .i_phase   (r_phase),
        .i_partial (r_partial),
        .o_dec     (dec)
    );

    ude_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (dec.res0),
        .i_res1   (dec.res1),
        .i_pop    (!i_stall),
        .o_res    (q_res),
        .o_valid  (o_valid),
        .o_room   (q_room),
        .o_count  (q_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_ACCEPT;
            r_partial <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_phase   <= dec.phase;
                r_partial <= dec.partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_byte_in;
        end
    end

    assign o_code_point  = q_res.code_point;
    assign o_escape_stop = q_res.escape_stop;
    assign o_last_of_run = q_res.last_of_run;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_esc_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_escape_stop |-> (o_code_point == '0) && o_last_of_run)
        else $error("escape marker word malformed");

    a_esc_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_byte == ESC_BYTE) |=> (r_phase == PH_ACCEPT) && (r_partial == '0))
        else $error("escape byte did not return decoder to accept");

    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_point <= 21'h10FFFF))
        else $error("code point out of range");
`endif

endmodule

// ===== tb/utf8_decode_checker.sv =====
// Checker for the UTF-8 decoder: predicts result words per input byte and compares them.
module utf8_decode_checker import ude_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  logic [7:0]      i_byte,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  logic [CP_W-1:0] i_code_point,
    input  logic            i_escape_stop,
    input  logic            i_last_of_run,
    output int              o_fail_count,
    output int              o_words_owed
);

    t_phase          dec_phase = PH_ACCEPT;
    logic [CP_W-1:0] partial   = '0;
    t_result         expected_words[$];
    t_result         want;
    int              n_fail = 0;

    function automatic t_result mk_word(input logic [CP_W-1:0] cp, input logic esc);
        t_result w;
        w.code_point  = cp;
        w.escape_stop = esc;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    // Byte at a character start; returns 1 when it yields a word at once.
    function automatic logic start_char(input logic [7:0] b, output logic [CP_W-1:0] cp);
        cp = REPL_CHAR;
        if (b < 8'h80) begin
            cp = CP_W'(b);
            return 1'b1;
        end
        if (b >= 8'hC2 && b <= 8'hDF) begin
            partial   = CP_W'(b[4:0]);
            dec_phase = PH_NEED1;
        end else if (b == 8'hE0) begin
            partial   = '0;
            dec_phase = PH_NEED2_E0;
        end else if (b == 8'hED) begin
            partial   = CP_W'(4'hD);
            dec_phase = PH_NEED2_ED;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
            partial   = CP_W'(b[3:0]);
            dec_phase = PH_NEED2;
        end else if (b == 8'hF0) begin
            partial   = '0;
            dec_phase = PH_NEED3_F0;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
            partial   = CP_W'(b[2:0]);
            dec_phase = PH_NEED3;
        end else if (b == 8'hF4) begin
            partial   = CP_W'(3'd4);
            dec_phase = PH_NEED3_F4;
        end else begin
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        t_result         words[$];
        logic [CP_W-1:0] cp;
        logic [7:0]      lo;
        logic [7:0]      hi;
        if (b == ESC_BYTE) begin
            if (dec_phase != PH_ACCEPT)
                words.push_back(mk_word(REPL_CHAR, 1'b0));
            dec_phase = PH_ACCEPT;
            partial   = '0;
            words.push_back(mk_word('0, 1'b1));
        end else if (dec_phase != PH_ACCEPT) begin
            lo = 8'h80;
            hi = 8'hBF;
            case (dec_phase)
                PH_NEED2_E0: lo = 8'hA0;
                PH_NEED2_ED: hi = 8'h9F;
                PH_NEED3_F0: lo = 8'h90;
                PH_NEED3_F4: hi = 8'h8F;
                default: ;
            endcase
            if (b >= lo && b <= hi) begin
                partial = {partial[CP_W-7:0], b[5:0]};
                case (dec_phase)
                    PH_NEED1:                           dec_phase = PH_ACCEPT;
                    PH_NEED2, PH_NEED2_E0, PH_NEED2_ED: dec_phase = PH_NEED1;
                    default:                            dec_phase = PH_NEED2;
                endcase
                if (dec_phase == PH_ACCEPT)
                    words.push_back(mk_word(partial, 1'b0));
            end else begin
                words.push_back(mk_word(REPL_CHAR, 1'b0));
                dec_phase = PH_ACCEPT;
                partial   = '0;
                if (start_char(b, cp))
                    words.push_back(mk_word(cp, 1'b0));
            end
        end else if (start_char(b, cp)) begin
            words.push_back(mk_word(cp, 1'b0));
        end
        if (words.size() > 0)
            words[words.size()-1].last_of_run = 1'b1;
        foreach (words[k])
            expected_words.push_back(words[k]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_phase = PH_ACCEPT;
            partial   = '0;
            expected_words.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                decode_byte(i_byte);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected word: cp=%h esc=%b last=%b",
                                 i_code_point, i_escape_stop, i_last_of_run);
                    n_fail++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_code_point !== want.code_point || i_escape_stop !== want.escape_stop
                        || i_last_of_run !== want.last_of_run) begin
                        if (n_fail < 10)
                            $display("word mismatch: expected cp=%h esc=%b last=%b, got cp=%h esc=%b last=%b",
                                     want.code_point, want.escape_stop, want.last_of_run,
                                     i_code_point, i_escape_stop, i_last_of_run);
                        n_fail++;
                    end
                end
            end
        end
        o_fail_count <= n_fail;
        o_words_owed <= expected_words.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench: byte stimulus, output stalls, watchdog and verdict for the decoder.
module tb;
    import ude_pkg::*;

    localparam int N_RANDOM    = 1300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic [7:0]      i_byte_in;
    logic            i_stall;
    logic            o_stall;
    logic            o_valid;
    logic [CP_W-1:0] o_code_point;
    logic            o_escape_stop;
    logic            o_last_of_run;

    int         fail_count;
    int         words_owed;
    int         idle_cycles = 0;
    int         sent;
    int         pick;
    bit         rx_hold_req = 1'b0;
    bit         tight = 1'b0;
    logic [7:0] byte_q[$];
    logic [7:0] directed_bytes[$] = '{
        8'h00, 8'h7F,
        8'hC2, 8'h80,
        8'hE0, 8'hA0, 8'h80,
        8'hED, 8'h9F, 8'hBF,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hC1, 8'hFF, 8'h80,
        8'hED, 8'hA0,
        8'hC2, 8'h41,
        8'hE1, 8'h1B,
        8'h1B
    };

    utf8_decode_until_escape dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_byte_in     (i_byte_in),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_code_point  (o_code_point),
        .o_escape_stop (o_escape_stop),
        .o_last_of_run (o_last_of_run),
        .i_stall       (i_stall)
    );

    utf8_decode_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_byte        (i_byte_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_code_point  (o_code_point),
        .i_escape_stop (o_escape_stop),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_words_owed  (words_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Mostly well-formed characters; some truncated by a random byte or an escape.
    task automatic queue_sequence;
        logic [7:0] seq[$];
        logic [7:0] lead;
        int         kind;
        int         keep;
        kind = $urandom_range(0, 10);
        if (kind < 3) begin
            seq.push_back(rand_byte(8'h00, 8'h7F));
        end else if (kind == 3) begin
            seq.push_back(ESC_BYTE);
        end else if (kind == 4) begin
            seq.push_back(rand_byte(0, 255));
        end else if (kind < 7) begin
            seq.push_back(rand_byte(8'hC2, 8'hDF));
            seq.push_back(rand_byte(8'h80, 8'hBF));
        end else if (kind < 9) begin
            lead = rand_byte(8'hE0, 8'hEF);
            seq.push_back(lead);
            if (lead == 8'hE0)
                seq.push_back(rand_byte(8'hA0, 8'hBF));
            else if (lead == 8'hED)
                seq.push_back(rand_byte(8'h80, 8'h9F));
            else
                seq.push_back(rand_byte(8'h80, 8'hBF));
            seq.push_back(rand_byte(8'h80, 8'hBF));
        end else begin
            lead = rand_byte(8'hF0, 8'hF4);
            seq.push_back(lead);
            if (lead == 8'hF0)
                seq.push_back(rand_byte(8'h90, 8'hBF));
            else if (lead == 8'hF4)
                seq.push_back(rand_byte(8'h80, 8'h8F));
            else
                seq.push_back(rand_byte(8'h80, 8'hBF));
            seq.push_back(rand_byte(8'h80, 8'hBF));
            seq.push_back(rand_byte(8'h80, 8'hBF));
        end
        if (seq.size() > 1 && $urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, seq.size() - 1);
            while (seq.size() > keep)
                void'(seq.pop_back());
            seq.push_back($urandom_range(0, 5) == 0 ? ESC_BYTE : rand_byte(0, 255));
        end
        foreach (seq[k])
            byte_q.push_back(seq[k]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        int r;
        r   = $urandom_range(0, 19);
        gap = (tight || r < 13) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (words_owed != 0)
            @(posedge i_clk);
    endtask

    // Output side stalls; one long forced hold when requested.
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else if (pick < 18) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_byte_in <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        drain();

        sent = 0;
        while (sent < N_RANDOM) begin
            if (byte_q.size() == 0)
                queue_sequence();
            if (sent % 64 == 0)
                tight = ($urandom_range(0, 3) == 0);
            if (sent == 400)
                drain();
            if (sent == 700)
                rx_hold_req = 1'b1;
            send_byte(byte_q.pop_front());
            sent++;
        end
        drain();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && words_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
